### rtl/core/key_directory_table_assert.svh
// ----------------------------------------------------------------------------
// Key directory table assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEY_DIRECTORY_TABLE_ASSERT_SVH
`define KEY_DIRECTORY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/kdt_pkg.sv
// ----------------------------------------------------------------------------
// Key directory table package
// Shared constants, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int KDT_ENTRIES   = 64;
    localparam int KDT_KEY_BYTES = 8;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int KEY_IN_W = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE = 2'd0,
        FN_DELETE = 2'd1,
        FN_LIST   = 2'd2,
        FN_UNUSED = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED    = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_FULL       = 3'd2,
        ST_DELETED    = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_LIST_ENTRY = 3'd5,
        ST_LIST_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot;
        logic [KEY_IN_W-1:0]   entry_key;
        logic                  last;
    } rsp_t;

endpackage

### rtl/core/kdt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered, held when idle.
// ----------------------------------------------------------------------------
module kdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/kdt_seq.sv
// ----------------------------------------------------------------------------
// Key directory table sequencer
// Walks the slots one per cycle via the key RAM and one comparator, waiting
// while the output register cannot take a result; keeps the valid bits.
// ----------------------------------------------------------------------------
module kdt_seq #(
    parameter int ENTRIES   = kdt_pkg::KDT_ENTRIES,
    parameter int KEY_BYTES = kdt_pkg::KDT_KEY_BYTES
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  kdt_pkg::func_t                               start_func,
    input  logic [KEY_BYTES*8-1:0]                       start_key,
    output logic                                         idle,
    input  logic                                         out_free,
    output logic                                         rsp_valid,
    output kdt_pkg::rsp_t                                rsp,
    output logic                                         rd_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    input  logic [KEY_BYTES*8-1:0]                       rd_data,
    output logic                                         wr_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    output logic [KEY_BYTES*8-1:0]                       wr_data
);

    import kdt_pkg::*;

    localparam int KEY_W = KEY_BYTES * 8;
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW    = $clog2(ENTRIES + 1);

    seq_state_t         state_reg, state_next;
    func_t              func_reg, func_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic               free_found_reg, free_found_next;
    logic [AW-1:0]      free_idx_reg, free_idx_next;
    logic               any_reg, any_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic vbit;
    logic hit;
    logic more_above;
    logic emit_now;
    logic advance;
    logic issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            pv_reg         <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            valid_reg      <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pv_reg         <= pv_next;
            free_found_reg <= free_found_next;
            any_reg        <= any_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        pidx_reg     <= pidx_next;
        free_idx_reg <= free_idx_next;
    end

    // While pv_reg is set, the RAM output belongs to the compare-stage slot.
    assign vbit       = valid_reg[pidx_reg];
    assign hit        = vbit && (rd_data == key_reg);
    assign more_above = ((valid_reg >> pidx_reg) >> 1) != '0;
    assign emit_now   = pv_reg && ((func_reg == FN_LIST) ? vbit : hit);
    assign advance    = !emit_now || out_free;
    assign issue      = idx_reg < IW'(ENTRIES);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_next        = any_reg;
        valid_next      = valid_reg;

        idle            = 1'b0;
        rsp_valid       = 1'b0;
        rsp.status      = ST_CREATED;
        rsp.slot        = '0;
        rsp.entry_key   = KEY_IN_W'(key_reg);
        rsp.last        = 1'b1;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = free_idx_reg;
        wr_data         = key_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    func_next       = start_func;
                    key_next        = start_key;
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    free_found_next = 1'b0;
                    any_next        = 1'b0;
                    if (start_func != FN_UNUSED)
                    begin
                        state_next = SEQ_SCAN;
                    end
                end
            end

            SEQ_SCAN:
            begin
                if (advance)
                begin
                    rd_en     = issue;
                    idx_next  = issue ? idx_reg + IW'(1) : idx_reg;
                    pv_next   = issue;
                    pidx_next = idx_reg[AW-1:0];
                    if (pv_reg)
                    begin
                        unique case (func_reg)
                            FN_CREATE:
                            begin
                                if (hit)
                                begin
                                    rsp_valid  = 1'b1;
                                    rsp.status = ST_DUPLICATE;
                                    state_next = SEQ_IDLE;
                                end
                                else if (!vbit && !free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = pidx_reg;
                                end
                            end
                            FN_DELETE:
                            begin
                                if (hit)
                                begin
                                    valid_next[pidx_reg] = 1'b0;
                                    rsp_valid  = 1'b1;
                                    rsp.status = ST_DELETED;
                                    rsp.slot   = SLOT_W'(pidx_reg);
                                    state_next = SEQ_IDLE;
                                end
                            end
                            FN_LIST:
                            begin
                                if (vbit)
                                begin
                                    rsp_valid     = 1'b1;
                                    rsp.status    = ST_LIST_ENTRY;
                                    rsp.slot      = SLOT_W'(pidx_reg);
                                    rsp.entry_key = KEY_IN_W'(rd_data);
                                    rsp.last      = !more_above;
                                    any_next      = 1'b1;
                                end
                            end
                            default:
                            begin
                                state_next = SEQ_IDLE;
                            end
                        endcase
                    end
                    else if (!issue)
                    begin
                        state_next = SEQ_FINISH;
                    end
                end
            end

            SEQ_FINISH:
            begin
                unique case (func_reg)
                    FN_CREATE:
                    begin
                        if (out_free)
                        begin
                            rsp_valid  = 1'b1;
                            state_next = SEQ_IDLE;
                            if (free_found_reg)
                            begin
                                wr_en                    = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                rsp.status               = ST_CREATED;
                                rsp.slot                 = SLOT_W'(free_idx_reg);
                            end
                            else
                            begin
                                rsp.status = ST_FULL;
                            end
                        end
                    end
                    FN_DELETE:
                    begin
                        if (out_free)
                        begin
                            rsp_valid  = 1'b1;
                            rsp.status = ST_NOT_FOUND;
                            state_next = SEQ_IDLE;
                        end
                    end
                    FN_LIST:
                    begin
                        if (any_reg)
                        begin
                            state_next = SEQ_IDLE;
                        end
                        else if (out_free)
                        begin
                            rsp_valid  = 1'b1;
                            rsp.status = ST_LIST_EMPTY;
                            state_next = SEQ_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = SEQ_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/key_directory_table.sv
// ----------------------------------------------------------------------------
// Key directory table
// Fixed table of keyed slots: create, delete and list requests, one result
// register toward the consumer.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   func, key
//  output    out_valid / out_ready status, slot, entry_key, last
//
// Create and delete walk the slots one per cycle through the key RAM read
// port and one comparator, waiting while a result finds the result register
// full; a hit ends the walk early. A list walks the slots the same way and
// pauses while each of its results waits for the consumer.
// The block takes a new request only when the sequencer is idle; the result
// register may still hold an unread result. Unused function codes are
// dropped at once. Reset clears all valid bits at once; there is no
// clearing pass.
module key_directory_table #(
    parameter int ENTRIES   = kdt_pkg::KDT_ENTRIES,
    parameter int KEY_BYTES = kdt_pkg::KDT_KEY_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [kdt_pkg::FUNC_W-1:0]      func,
    input  logic [kdt_pkg::KEY_IN_W-1:0]    key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kdt_pkg::STATUS_W-1:0]    status,
    output logic [kdt_pkg::SLOT_W-1:0]      slot,
    output logic [kdt_pkg::KEY_IN_W-1:0]    entry_key,
    output logic                            last
);

    import kdt_pkg::*;

    `include "key_directory_table_assert.svh"

    localparam int KEY_W = KEY_BYTES * 8;
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic             start;
    logic             seq_idle;
    logic             out_free;
    logic             rsp_valid;
    rsp_t             rsp;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    logic             out_valid_reg, out_valid_next;
    rsp_t             out_rsp_reg;

    logic             scan_start;
    logic             slotless_out;

    assign in_ready = seq_idle;
    assign start    = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    kdt_seq #(
        .ENTRIES   (ENTRIES),
        .KEY_BYTES (KEY_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_func (func_t'(func)),
        .start_key  (key[KEY_W-1:0]),
        .idle       (seq_idle),
        .out_free   (out_free),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    kdt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_rsp_reg.status;
    assign slot      = out_rsp_reg.slot;
    assign entry_key = out_rsp_reg.entry_key;
    assign last      = out_rsp_reg.last;

    assign scan_start   = start && (func_t'(func) != FN_UNUSED);
    assign slotless_out = out_valid && ((status == ST_DUPLICATE) || (status == ST_FULL) ||
                                        (status == ST_NOT_FOUND) || (status == ST_LIST_EMPTY));

    // A new result may only be loaded when the result register can take it.
    `KDT_ASSERT_NOW(a_rsp_into_free_reg, rsp_valid, out_free, "result loaded over an unread result")

    // Any real request leaves the block busy in the cycle after it is accepted.
    `KDT_ASSERT_NEXT(a_busy_after_request, scan_start, !in_ready, "request accepted during a scan")

    // Results that name no slot carry slot zero and end their request.
    `KDT_ASSERT_NOW(a_no_slot_results, slotless_out, (slot == '0) && last, "bad slotless result")

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Key directory table testbench
// Sends create, delete, list and unused requests through the valid/ready
// input channel and keeps its own copy of the slot table. Every result is
// checked field by field against the oldest predicted result. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdt_pkg::*;

    localparam int ENTRIES     = KDT_ENTRIES;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [KEY_IN_W-1:0] KEY_MASK =
        (KDT_KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KDT_KEY_BYTES)) - 64'd1);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [FUNC_W-1:0]     func = FN_CREATE;
    logic [KEY_IN_W-1:0]   key = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_IN_W-1:0]   entry_key;
    logic                  last;

    // Shadow copy of the directory and the results it still owes.
    logic                  dir_valid [ENTRIES];
    logic [KEY_IN_W-1:0]   dir_key [ENTRIES];
    rsp_t                  pending_results [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  rx_stall_left = 0;

    key_directory_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot),
        .entry_key (entry_key),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** key_directory_table: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KEY_IN_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int count_used();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i])
                n++;
        return n;
    endfunction

    function automatic int find_entry(logic [KEY_IN_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && dir_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_result(status_t st, int s, logic [KEY_IN_W-1:0] k,
                                        logic lst);
        rsp_t r;
        r.status    = st;
        r.slot      = s[SLOT_W-1:0];
        r.entry_key = k;
        r.last      = lst;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted request to the shadow directory and queues the
    // results it must produce.
    function automatic void predict_request(func_t f, logic [KEY_IN_W-1:0] raw_key);
        logic [KEY_IN_W-1:0] k;
        int                  hit;
        int                  free_slot;
        int                  n;
        k = raw_key & KEY_MASK;
        case (f)
            FN_CREATE:
            begin
                hit = find_entry(k);
                free_slot = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!dir_valid[i])
                        free_slot = i;
                if (hit >= 0)
                    push_result(ST_DUPLICATE, 0, k, 1'b1);
                else if (free_slot >= 0)
                begin
                    dir_valid[free_slot] = 1'b1;
                    dir_key[free_slot]   = k;
                    push_result(ST_CREATED, free_slot, k, 1'b1);
                end
                else
                    push_result(ST_FULL, 0, k, 1'b1);
            end
            FN_DELETE:
            begin
                hit = find_entry(k);
                if (hit >= 0)
                begin
                    dir_valid[hit] = 1'b0;
                    push_result(ST_DELETED, hit, k, 1'b1);
                end
                else
                    push_result(ST_NOT_FOUND, 0, k, 1'b1);
            end
            FN_LIST:
            begin
                n = count_used();
                if (n == 0)
                    push_result(ST_LIST_EMPTY, 0, k, 1'b1);
                for (int i = 0; i < ENTRIES; i++)
                    if (dir_valid[i])
                    begin
                        n--;
                        push_result(ST_LIST_ENTRY, i, dir_key[i], n == 0);
                    end
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(func_t f, logic [KEY_IN_W-1:0] k);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(f, k);
    endtask

    task automatic report_mismatch(string what);
        $display("cycle %0d: mismatch: %s", cycle_count, what);
        error_count++;
    endtask

    // Consumer side: random stalls of varied length.
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            out_ready     <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end
        else if (rst_n && rx_idle_en && $urandom_range(0, 9) == 0)
        begin
            out_ready     <= 1'b0;
            rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
        end
        else
            out_ready <= rst_n;
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d slot %0d key %h",
                                          status, slot, entry_key));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
                if (entry_key !== want.entry_key)
                    report_mismatch($sformatf("entry_key got %h want %h",
                                              entry_key, want.entry_key));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %b want %b", last, want.last));
            end
        end
    end

    // Starts from the empty table left by reset.
    task automatic test_basic_requests();
        logic [KEY_IN_W-1:0] k_rand;
        k_rand = random_key();
        send_request(FN_LIST, '1);
        send_request(FN_DELETE, k_rand);
        send_request(FN_CREATE, '0);
        send_request(FN_CREATE, '1);
        send_request(FN_CREATE, '0);
        send_request(FN_CREATE, k_rand);
        send_request(FN_UNUSED, random_key());
        send_request(FN_LIST, random_key());
        send_request(FN_DELETE, '1);
        send_request(FN_DELETE, '1);
        send_request(FN_CREATE, 64'h8000_0000_0000_0000);
        send_request(FN_UNUSED, '1);
        send_request(FN_LIST, '0);
        send_request(FN_DELETE, '0);
        send_request(FN_DELETE, 64'h8000_0000_0000_0000);
        send_request(FN_DELETE, k_rand);
        send_request(FN_LIST, '0);
    endtask

    // Fills every slot, then probes the full table and the free-slot order.
    task automatic test_full_table();
        logic [KEY_IN_W-1:0] first_key;
        int                  seq;
        seq = 0;
        while (count_used() < ENTRIES)
        begin
            send_request(FN_CREATE, {$urandom(), 32'(seq)});
            seq++;
        end
        first_key = dir_key[0];
        send_request(FN_CREATE, random_key());
        send_request(FN_CREATE, dir_key[ENTRIES - 1]);
        send_request(FN_LIST, random_key());
        send_request(FN_DELETE, dir_key[ENTRIES - 1]);
        send_request(FN_DELETE, dir_key[ENTRIES / 2]);
        send_request(FN_DELETE, first_key);
        send_request(FN_CREATE, first_key);
        send_request(FN_CREATE, '1);
        send_request(FN_LIST, '0);
        // Thin the table out so the random part starts half full.
        for (int i = 0; i < ENTRIES; i += 2)
            if (dir_valid[i])
                send_request(FN_DELETE, dir_key[i]);
    endtask

    // Keys mostly come from a small pool so that duplicates and hits on
    // delete are common; the pool grows the table when creates dominate.
    task automatic test_random_traffic(int count);
        logic [KEY_IN_W-1:0] key_pool [48];
        logic [KEY_IN_W-1:0] k;
        int                  r;
        int                  create_pct;
        for (int i = 0; i < 48; i++)
            key_pool[i] = (i < 8) ? 64'(i) : random_key();
        for (int i = 0; i < count; i++)
        begin
            tx_idle_en = !(i >= 100 && i < 125);
            rx_idle_en = !(i >= 100 && i < 125);
            create_pct = (i < 50) ? 70 : (i < 100) ? 50 : 30;
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 47)]
                                             : random_key();
            r = $urandom_range(0, 99);
            if (r < 7)
                send_request(FN_LIST, k);
            else if (r < 10)
                send_request(FN_UNUSED, k);
            else if ($urandom_range(0, 99) < create_pct)
                send_request(FN_CREATE, k);
            else
                send_request(FN_DELETE, k);
        end
    endtask

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_key[i]   = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_full_table();
        test_random_traffic(110);

        // Drop valid right at the accepting edge of the last request.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 20) @(posedge clk);

        if (error_count == 0)
            $display("** key_directory_table: PASSED **");
        else
            $display("** key_directory_table: FAILED **");
        $finish;
    end

endmodule

### key_directory_table.f
+incdir+rtl/core
rtl/core/kdt_pkg.sv
rtl/core/kdt_ram.sv
rtl/core/kdt_seq.sv
rtl/core/key_directory_table.sv
tb/tb.sv
